[rtl/swerve_wheel_inverse_kinematics_unit_macros.svh]
// Assertion helpers for the swerve kinematics RTL.
`ifndef SWERVE_WHEEL_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`define SWERVE_WHEEL_INVERSE_KINEMATICS_UNIT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define SWK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SWK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/swk_pkg.sv]
package swk_pkg;

  localparam int ATAN_LEN = 24;
  localparam int ZW = 34;
  localparam int CW = 30;
  localparam int MAX_STAGES = 24;
  localparam logic [29:0] INV_GAIN = 30'd652032874;
  localparam logic [17:0] SPEED_MAX = 18'd131071;
  localparam logic signed [15:0] QUARTER = 16'sd16384;

  typedef enum logic [1:0] {
    REG_GAIN = 2'd0,
    REG_HALF_LENGTH = 2'd1,
    REG_HALF_WIDTH = 2'd2
  } reg_idx_t;

  // Per-wheel control carried alongside the CORDIC data.
  typedef struct packed {
    logic neg;
    logic x_zero;
    logic y_pos;
    logic y_zero;
  } wheel_flags_t;

  function automatic logic signed [ZW-1:0] atan_of(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 34'sd536870912;
        1: r = 34'sd316933406;
        2: r = 34'sd167458907;
        3: r = 34'sd85004756;
        4: r = 34'sd42667331;
        5: r = 34'sd21354465;
        6: r = 34'sd10679838;
        7: r = 34'sd5340245;
        8: r = 34'sd2670163;
        9: r = 34'sd1335087;
        10: r = 34'sd667544;
        11: r = 34'sd333772;
        12: r = 34'sd166886;
        13: r = 34'sd83443;
        14: r = 34'sd41722;
        15: r = 34'sd20861;
        16: r = 34'sd10430;
        17: r = 34'sd5215;
        18: r = 34'sd2608;
        19: r = 34'sd1304;
        20: r = 34'sd652;
        21: r = 34'sd326;
        22: r = 34'sd163;
        23: r = 34'sd81;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/swk_cordic_cell.sv]
module swk_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [swk_pkg::CW-1:0]     x_in,
  input  logic signed [swk_pkg::CW-1:0]     y_in,
  input  logic signed [swk_pkg::ZW-1:0]     z_in,
  output logic signed [swk_pkg::CW-1:0]     x_out,
  output logic signed [swk_pkg::CW-1:0]     y_out,
  output logic signed [swk_pkg::ZW-1:0]     z_out
);

  logic signed [swk_pkg::CW-1:0] dx, dy;
  logic signed [swk_pkg::ZW-1:0] at;

  assign dx = x_in >>> STAGE;
  assign dy = y_in >>> STAGE;
  assign at = swk_pkg::atan_of(STAGE);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[swk_pkg::CW-1]) begin
        x_out <= x_in + dy;
        y_out <= y_in - dx;
        z_out <= z_in + at;
      end else begin
        x_out <= x_in - dy;
        y_out <= y_in + dx;
        z_out <= z_in - at;
      end
    end
  end

endmodule

[rtl/swk_wheel_lane.sv]
module swk_wheel_lane #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [27:0]            cx,
  input  logic signed [27:0]            cy,
  output logic signed [15:0]            angle,
  output logic [17:0]                   mag,
  output logic                          neg
);

  localparam int CW = swk_pkg::CW;
  localparam int ZW = swk_pkg::ZW;
  localparam int NS = (STAGES < swk_pkg::ATAN_LEN) ? STAGES : swk_pkg::ATAN_LEN;

  logic signed [CW-1:0] xs [0:NS];
  logic signed [CW-1:0] ys [0:NS];
  logic signed [ZW-1:0] zs [0:NS];
  swk_pkg::wheel_flags_t fl_r [0:NS+1];
  logic [27:0] ay_r [0:NS+1];
  logic signed [ZW-1:0] zr_r;
  logic [29+30:0] prod_r;
  logic signed [ZW-1:0] zrnd;
  logic signed [ZW-17:0] zq;
  logic [60:0] psum;
  logic [22:0] pm;
  logic [20:0] ym;
  logic [27:0] cy_abs;

  // Stage 0 of the row: fold the vector into the right half plane.
  assign cy_abs = cy[27] ? 28'(-cy) : cy;
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= cx[27] ? CW'(-cx) : CW'(cx);
      ys[0] <= cx[27] ? CW'(-cy) : CW'(cy);
      zs[0] <= '0;
      fl_r[0] <= '{neg: cx[27], x_zero: (cx == '0), y_pos: (!cy[27] && cy != '0),
                   y_zero: (cy == '0)};
      ay_r[0] <= cy_abs;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cell
    swk_cordic_cell #(.STAGE(i)) u_cell (
      .clk(clk), .en(en),
      .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[i+1] <= fl_r[i];
        ay_r[i+1] <= ay_r[i];
      end
    end
  end

  // Gain correction multiply, registered before rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 60'(xs[NS][CW-2:0]) * 60'(swk_pkg::INV_GAIN);
      zr_r <= zs[NS];
      fl_r[NS+1] <= fl_r[NS];
      ay_r[NS+1] <= ay_r[NS];
    end
  end

  assign zrnd = zr_r + ZW'(32768);
  assign zq = zrnd[ZW-1:16];
  assign psum = 61'(prod_r) + (61'(1) << 37);
  assign pm = psum[60:38];
  assign ym = 21'((29'(ay_r[NS+1]) + 29'd128) >> 8);

  always_comb begin
    neg = 1'b0;
    if (fl_r[NS+1].x_zero) begin
      angle = fl_r[NS+1].y_zero ? '0 : (fl_r[NS+1].y_pos ? swk_pkg::QUARTER
                                                         : -swk_pkg::QUARTER);
      mag = (ym > 21'(swk_pkg::SPEED_MAX)) ? swk_pkg::SPEED_MAX : ym[17:0];
    end else begin
      neg = fl_r[NS+1].neg;
      if (zq > 18'sd16384) angle = swk_pkg::QUARTER;
      else if (zq < -18'sd16384) angle = -swk_pkg::QUARTER;
      else angle = zq[15:0];
      mag = (pm > 23'(swk_pkg::SPEED_MAX)) ? swk_pkg::SPEED_MAX : pm[17:0];
    end
  end

endmodule

[rtl/swerve_wheel_inverse_kinematics_unit.sv]
// Swerve wheel inverse kinematics: each force word (force_x, force_y,
// torque_z in Q8.8) is scaled by admittance_gain into chassis velocities,
// split into four wheel vectors using half_length and half_width, and each
// vector runs through its own row of vectoring cells, CORDIC_STAGES of them
// but at most ATAN_LEN. One word is accepted per cycle while the pipe is not
// stalled; each word passes through the velocity register (loaded at the
// accepting edge), the wheel-vector stage, one fold stage, the cell row, one
// gain-correction multiply and one output register. The whole pipe advances
// whenever the output register is empty or being taken, so backpressure
// stalls every stage together.
// Configuration writes must only happen while the pipe is empty.
`include "swerve_wheel_inverse_kinematics_unit_macros.svh"
module swerve_wheel_inverse_kinematics_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_force_x,
  input  logic signed [15:0]  in_force_y,
  input  logic signed [15:0]  in_torque_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_angle_front_left,
  output logic signed [15:0]  out_angle_rear_left,
  output logic signed [15:0]  out_angle_rear_right,
  output logic signed [15:0]  out_angle_front_right,
  output logic signed [17:0]  out_speed_front_left,
  output logic signed [17:0]  out_speed_rear_left,
  output logic signed [17:0]  out_speed_rear_right,
  output logic signed [17:0]  out_speed_front_right
);

  localparam int NS = (CORDIC_STAGES < swk_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                          : swk_pkg::ATAN_LEN;
  // velocity stage, wheel-vector stage, fold, cells, multiply
  localparam int DEPTH = NS + 4;

  logic [15:0] gain_r;
  logic [9:0]  hl_r, hw_r;
  logic        adv;
  logic [DEPTH-1:0] vld_r, vld_nxt;

  logic signed [31:0] px, py, pz;
  logic signed [16:0] vx_r, vy_r, wz_r;
  logic signed [27:0] cxm_r, cxp_r, cyp_r, cym_r;
  logic signed [27:0] bw, aw, ax, ay;
  logic signed [15:0] ang [0:3];
  logic [17:0] mag [0:3];
  logic neg [0:3];

  // Hold the whole pipe while a result waits untaken.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd624;
      hl_r <= 10'd64;
      hw_r <= 10'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swk_pkg::REG_GAIN:        gain_r <= cfg_data;
        swk_pkg::REG_HALF_LENGTH: hl_r <= cfg_data[9:0];
        swk_pkg::REG_HALF_WIDTH:  hw_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Admittance scale with round half up.
  assign px = in_force_x * $signed({1'b0, gain_r}) + 32'sd32768;
  assign py = in_force_y * $signed({1'b0, gain_r}) + 32'sd32768;
  assign pz = in_torque_z * $signed({1'b0, gain_r}) + 32'sd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r <= 17'($signed(px[31:16]));
      vy_r <= 17'($signed(py[31:16]));
      wz_r <= 17'($signed(pz[31:16]));
    end
  end

  assign bw = 28'(wz_r) * $signed({18'd0, hw_r});
  assign aw = 28'(wz_r) * $signed({18'd0, hl_r});
  assign ax = 28'(vx_r) <<< 8;
  assign ay = 28'(vy_r) <<< 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      cxm_r <= ax - bw;
      cxp_r <= ax + bw;
      cyp_r <= ay + aw;
      cym_r <= ay - aw;
    end
  end

  swk_wheel_lane #(.STAGES(NS)) u_fl (.clk(clk), .en(adv), .cx(cxm_r), .cy(cyp_r),
    .angle(ang[0]), .mag(mag[0]), .neg(neg[0]));
  swk_wheel_lane #(.STAGES(NS)) u_rl (.clk(clk), .en(adv), .cx(cxm_r), .cy(cym_r),
    .angle(ang[1]), .mag(mag[1]), .neg(neg[1]));
  swk_wheel_lane #(.STAGES(NS)) u_rr (.clk(clk), .en(adv), .cx(cxp_r), .cy(cym_r),
    .angle(ang[2]), .mag(mag[2]), .neg(neg[2]));
  swk_wheel_lane #(.STAGES(NS)) u_fr (.clk(clk), .en(adv), .cx(cxp_r), .cy(cyp_r),
    .angle(ang[3]), .mag(mag[3]), .neg(neg[3]));

  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
      out_valid <= vld_r[DEPTH-1];
    end
  end

  // Output register; the rear and front-right speeds are negated.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_front_left <= ang[0];
      out_angle_rear_left <= ang[1];
      out_angle_rear_right <= ang[2];
      out_angle_front_right <= ang[3];
      out_speed_front_left <= neg[0] ? -$signed(mag[0]) : $signed(mag[0]);
      out_speed_rear_left <= neg[1] ? $signed(mag[1]) : -$signed(mag[1]);
      out_speed_rear_right <= neg[2] ? $signed(mag[2]) : -$signed(mag[2]);
      out_speed_front_right <= neg[3] ? $signed(mag[3]) : -$signed(mag[3]);
    end
  end

  `SWK_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `SWK_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_valid, in_ready)
  `SWK_ASSERT_NEXT(a_pipe_shift, clk, rst_n, adv && in_valid, vld_r[0])
  `SWK_ASSERT_IMP(a_angle_range, clk, rst_n, out_valid,
    out_angle_front_left <= 16'sd16384 && out_angle_front_left >= -16'sd16384)

endmodule
